// ===== rtl/sit_pkg.sv =====
// Shared widths and operand types for the segment intersection pipeline.
package sit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

endpackage

// ===== rtl/sit_diff.sv =====
// Stage 1: endpoint differences r = B - A, s = D - C, q = C - A.
module sit_diff
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  sit_pkg::coord_t a_x,
    input  sit_pkg::coord_t a_y,
    input  sit_pkg::coord_t b_x,
    input  sit_pkg::coord_t b_y,
    input  sit_pkg::coord_t c_x,
    input  sit_pkg::coord_t c_y,
    input  sit_pkg::coord_t d_x,
    input  sit_pkg::coord_t d_y,
    output logic            dn_valid,
    input  logic            dn_stall,
    output sit_pkg::diff_t  rx,
    output sit_pkg::diff_t  ry,
    output sit_pkg::diff_t  sx,
    output sit_pkg::diff_t  sy,
    output sit_pkg::diff_t  qx,
    output sit_pkg::diff_t  qy
);

    logic           valid_reg;
    logic           valid_next;
    logic           advance;
    sit_pkg::diff_t rx_reg, ry_reg, sx_reg, sy_reg, qx_reg, qy_reg;

    assign advance    = !valid_reg || !dn_stall;
    assign up_stall   = !advance;
    assign valid_next = advance ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            rx_reg <= sit_pkg::DIFF_WIDTH'(b_x) - sit_pkg::DIFF_WIDTH'(a_x);
            ry_reg <= sit_pkg::DIFF_WIDTH'(b_y) - sit_pkg::DIFF_WIDTH'(a_y);
            sx_reg <= sit_pkg::DIFF_WIDTH'(d_x) - sit_pkg::DIFF_WIDTH'(c_x);
            sy_reg <= sit_pkg::DIFF_WIDTH'(d_y) - sit_pkg::DIFF_WIDTH'(c_y);
            qx_reg <= sit_pkg::DIFF_WIDTH'(c_x) - sit_pkg::DIFF_WIDTH'(a_x);
            qy_reg <= sit_pkg::DIFF_WIDTH'(c_y) - sit_pkg::DIFF_WIDTH'(a_y);
        end
    end

    assign dn_valid = valid_reg;
    assign rx = rx_reg;
    assign ry = ry_reg;
    assign sx = sx_reg;
    assign sy = sy_reg;
    assign qx = qx_reg;
    assign qy = qy_reg;

endmodule

// ===== rtl/sit_mult.sv =====
// Stage 2: the six cross-product terms, one multiplier each.
module sit_mult
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_stall,
    input  sit_pkg::diff_t rx,
    input  sit_pkg::diff_t ry,
    input  sit_pkg::diff_t sx,
    input  sit_pkg::diff_t sy,
    input  sit_pkg::diff_t qx,
    input  sit_pkg::diff_t qy,
    output logic           dn_valid,
    input  logic           dn_stall,
    output sit_pkg::prod_t rx_sy,
    output sit_pkg::prod_t ry_sx,
    output sit_pkg::prod_t qx_sy,
    output sit_pkg::prod_t qy_sx,
    output sit_pkg::prod_t qx_ry,
    output sit_pkg::prod_t qy_rx
);

    logic           valid_reg;
    logic           valid_next;
    logic           advance;
    sit_pkg::prod_t p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    assign advance    = !valid_reg || !dn_stall;
    assign up_stall   = !advance;
    assign valid_next = advance ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            p0_reg <= sit_pkg::PROD_WIDTH'(rx) * sit_pkg::PROD_WIDTH'(sy);
            p1_reg <= sit_pkg::PROD_WIDTH'(ry) * sit_pkg::PROD_WIDTH'(sx);
            p2_reg <= sit_pkg::PROD_WIDTH'(qx) * sit_pkg::PROD_WIDTH'(sy);
            p3_reg <= sit_pkg::PROD_WIDTH'(qy) * sit_pkg::PROD_WIDTH'(sx);
            p4_reg <= sit_pkg::PROD_WIDTH'(qx) * sit_pkg::PROD_WIDTH'(ry);
            p5_reg <= sit_pkg::PROD_WIDTH'(qy) * sit_pkg::PROD_WIDTH'(rx);
        end
    end

    assign dn_valid = valid_reg;
    assign rx_sy = p0_reg;
    assign ry_sx = p1_reg;
    assign qx_sy = p2_reg;
    assign qy_sx = p3_reg;
    assign qx_ry = p4_reg;
    assign qy_rx = p5_reg;

endmodule

// ===== rtl/sit_comb.sv =====
// Stage 3: determinant and the two Cramer numerators.
module sit_comb
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_stall,
    input  sit_pkg::prod_t rx_sy,
    input  sit_pkg::prod_t ry_sx,
    input  sit_pkg::prod_t qx_sy,
    input  sit_pkg::prod_t qy_sx,
    input  sit_pkg::prod_t qx_ry,
    input  sit_pkg::prod_t qy_rx,
    output logic           dn_valid,
    input  logic           dn_stall,
    output sit_pkg::sum_t  det,
    output sit_pkg::sum_t  tn,
    output sit_pkg::sum_t  un
);

    logic          valid_reg;
    logic          valid_next;
    logic          advance;
    sit_pkg::sum_t det_reg, tn_reg, un_reg;

    assign advance    = !valid_reg || !dn_stall;
    assign up_stall   = !advance;
    assign valid_next = advance ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            det_reg <= sit_pkg::SUM_WIDTH'(rx_sy) - sit_pkg::SUM_WIDTH'(ry_sx);
            tn_reg  <= sit_pkg::SUM_WIDTH'(qx_sy) - sit_pkg::SUM_WIDTH'(qy_sx);
            un_reg  <= sit_pkg::SUM_WIDTH'(qx_ry) - sit_pkg::SUM_WIDTH'(qy_rx);
        end
    end

    assign dn_valid = valid_reg;
    assign det = det_reg;
    assign tn  = tn_reg;
    assign un  = un_reg;

endmodule

// ===== rtl/sit_judge.sv =====
// Stage 4: parallel test and sign-aware range check, with the output register.
module sit_judge
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_stall,
    input  sit_pkg::sum_t det,
    input  sit_pkg::sum_t tn,
    input  sit_pkg::sum_t un,
    output logic          dn_valid,
    input  logic          dn_stall,
    output logic          segments_cross,
    output logic          lines_parallel
);

    logic valid_reg;
    logic valid_next;
    logic advance;
    logic cross_reg, cross_next;
    logic par_reg, par_next;
    logic det_zero;
    logic det_neg;

    // n/det in [0,1] without negation: compare against 0 and det by det's sign
    function automatic logic in_unit(input sit_pkg::sum_t n, input sit_pkg::sum_t d,
                                     input logic d_neg);
        logic n_neg;
        logic n_zero;
        begin
            n_neg  = n[sit_pkg::SUM_WIDTH-1];
            n_zero = (n == '0);
            if (d_neg)
            begin
                in_unit = (n_neg || n_zero) && (n >= d);
            end
            else
            begin
                in_unit = !n_neg && (n <= d);
            end
        end
    endfunction

    assign det_zero   = (det == '0);
    assign det_neg    = det[sit_pkg::SUM_WIDTH-1];
    assign par_next   = det_zero;
    assign cross_next = !det_zero && in_unit(tn, det, det_neg) && in_unit(un, det, det_neg);

    assign advance    = !valid_reg || !dn_stall;
    assign up_stall   = !advance;
    assign valid_next = advance ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            cross_reg <= cross_next;
            par_reg   <= par_next;
        end
    end

    assign dn_valid       = valid_reg;
    assign segments_cross = cross_reg;
    assign lines_parallel = par_reg;

    a_par_no_cross: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && par_reg |-> !cross_reg)
        else $error("parallel result also flagged as crossing");

    a_load_from_det: assert property (@(posedge clk) disable iff (!rst_n)
        advance && up_valid |=> par_reg == $past(det_zero))
        else $error("parallel flag does not match determinant");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && dn_stall |=> valid_reg && $stable(cross_reg) && $stable(par_reg))
        else $error("result changed while held");

endmodule

// ===== rtl/segment_intersection_test_top.sv =====
// Top level of the segment intersection test pipeline.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, a_x..d_y (16b signed)| request in
//  out     | out_valid, out_stall, segments_cross,    | result out
//          | lines_parallel                           |
//
// A result turns valid once its request has passed through four register stages:
// differences, six 17x17 multipliers, determinant and numerators, then the range check
// into the output register. One request enters every cycle while the output drains.
// Reset (rst_n, asynchronous, active low) clears the valid bits of all stages.
// Each stage holds its contents only when it is full and the stage after it
// stalls, so bubbles close up and in_stall rises only once all four are full.
module segment_intersection_test_top
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sit_pkg::coord_t a_x,
    input  sit_pkg::coord_t a_y,
    input  sit_pkg::coord_t b_x,
    input  sit_pkg::coord_t b_y,
    input  sit_pkg::coord_t c_x,
    input  sit_pkg::coord_t c_y,
    input  sit_pkg::coord_t d_x,
    input  sit_pkg::coord_t d_y,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            segments_cross,
    output logic            lines_parallel
);

    // stage 1 -> 2
    logic           v1, s1;
    sit_pkg::diff_t rx, ry, sx, sy, qx, qy;
    // stage 2 -> 3
    logic           v2, s2;
    sit_pkg::prod_t rx_sy, ry_sx, qx_sy, qy_sx, qx_ry, qy_rx;
    // stage 3 -> 4
    logic           v3, s3;
    sit_pkg::sum_t  det, tn, un;

    // Advance endpoint differences.
    sit_diff u_diff
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .a_x      (a_x),
        .a_y      (a_y),
        .b_x      (b_x),
        .b_y      (b_y),
        .c_x      (c_x),
        .c_y      (c_y),
        .d_x      (d_x),
        .d_y      (d_y),
        .dn_valid (v1),
        .dn_stall (s1),
        .rx       (rx),
        .ry       (ry),
        .sx       (sx),
        .sy       (sy),
        .qx       (qx),
        .qy       (qy)
    );

    // Form the six products in parallel.
    sit_mult u_mult
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v1),
        .up_stall (s1),
        .rx       (rx),
        .ry       (ry),
        .sx       (sx),
        .sy       (sy),
        .qx       (qx),
        .qy       (qy),
        .dn_valid (v2),
        .dn_stall (s2),
        .rx_sy    (rx_sy),
        .ry_sx    (ry_sx),
        .qx_sy    (qx_sy),
        .qy_sx    (qy_sx),
        .qx_ry    (qx_ry),
        .qy_rx    (qy_rx)
    );

    // Combine products into det, tn, un.
    sit_comb u_comb
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v2),
        .up_stall (s2),
        .rx_sy    (rx_sy),
        .ry_sx    (ry_sx),
        .qx_sy    (qx_sy),
        .qy_sx    (qy_sx),
        .qx_ry    (qx_ry),
        .qy_rx    (qy_rx),
        .dn_valid (v3),
        .dn_stall (s3),
        .det      (det),
        .tn       (tn),
        .un       (un)
    );

    // Decide and hold the result until taken.
    sit_judge u_judge
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (v3),
        .up_stall       (s3),
        .det            (det),
        .tn             (tn),
        .un             (un),
        .dn_valid       (out_valid),
        .dn_stall       (out_stall),
        .segments_cross (segments_cross),
        .lines_parallel (lines_parallel)
    );

    // A stall at the input means every stage holds a request.
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && v1 && v2 && v3)
        else $error("input stalled with an empty stage");

    // Without back-pressure at the output nothing stalls upstream.
    a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall && !s1 && !s2 && !s3)
        else $error("stall raised without output stall");

endmodule
